[hdl/sha256cr_pkg.sv]
// Shared types and constants for the SHA-256 compression rounds unit.
// Holds the word and state types, the initial hash values and the round-constant table.
// No dependencies.
package sha256cr_pkg;

  localparam int WORD_W    = 32;
  localparam int NUM_WORDS = 8;
  localparam int ROUND_W   = 6;
  localparam int CFG_IDX_W = 4;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [NUM_WORDS-1:0][WORD_W-1:0] hash_t;
  typedef logic [ROUND_W-1:0] round_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  // First and last round of a block.
  localparam round_t ROUND_FIRST = 6'd0;
  localparam round_t ROUND_LAST  = 6'd63;

  // Standard SHA-256 initial hash, used as the reset value of the initial-hash registers.
  localparam word_t HASH_RESET [NUM_WORDS] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  // Standard SHA-256 round constants.
  localparam word_t ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

endpackage

[hdl/sha256cr_cfg_regs.sv]
// Initial-hash configuration registers of the SHA-256 compression rounds unit.
// Depends on sha256cr_pkg for the word types and the reset values.
module sha256cr_cfg_regs (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr_en,
  input  sha256cr_pkg::cfg_idx_t wr_index,
  input  sha256cr_pkg::word_t   wr_data,
  output sha256cr_pkg::hash_t   init_hash
);
  import sha256cr_pkg::*;

  // One register per initial chaining word; writes beyond the last index are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_WORDS; i++) begin
        init_hash[i] <= HASH_RESET[i];
      end
    end else if (wr_en) begin
      for (int i = 0; i < NUM_WORDS; i++) begin
        if (wr_index == CFG_IDX_W'(i)) begin
          init_hash[i] <= wr_data;
        end
      end
    end
  end

endmodule

[hdl/sha256cr_round.sv]
// Combinational logic of one SHA-256 round on the eight working words a..h.
// Depends on sha256cr_pkg for the word and state types.
module sha256cr_round (
  input  sha256cr_pkg::hash_t vars,
  input  sha256cr_pkg::word_t sched_word,
  input  sha256cr_pkg::word_t round_k,
  output sha256cr_pkg::hash_t vars_next
);
  import sha256cr_pkg::*;

  function automatic word_t rotr(input word_t x, input int n);
    rotr = (x >> n) | (x << (WORD_W - n));
  endfunction

  word_t big_s1;
  word_t choose;
  word_t big_s0;
  word_t major;
  word_t t1;
  word_t t2;

  // Round functions on e (word 4) and a (word 0).
  always_comb begin
    big_s1 = rotr(vars[4], 6) ^ rotr(vars[4], 11) ^ rotr(vars[4], 25);
    choose = (vars[4] & vars[5]) ^ (~vars[4] & vars[6]);
    t1     = vars[7] + big_s1 + choose + round_k + sched_word;
    big_s0 = rotr(vars[0], 2) ^ rotr(vars[0], 13) ^ rotr(vars[0], 22);
    major  = (vars[0] & vars[1]) ^ (vars[0] & vars[2]) ^ (vars[1] & vars[2]);
    t2     = big_s0 + major;
  end

  // The words shift down by one place, with new values entering at a and e.
  always_comb begin
    vars_next[7] = vars[6];
    vars_next[6] = vars[5];
    vars_next[5] = vars[4];
    vars_next[4] = vars[3] + t1;
    vars_next[3] = vars[2];
    vars_next[2] = vars[1];
    vars_next[1] = vars[0];
    vars_next[0] = t1 + t2;
  end

endmodule

[hdl/sha256_compression_rounds_unit.sv]
// Top level of the SHA-256 compression rounds unit: input register, round state and digest register.
// Depends on sha256cr_pkg, sha256cr_cfg_regs and sha256cr_round.
//
//  Channel | Handshake          | Payload
//  --------+--------------------+------------------------------------------
//  in      | in_valid/in_ready  | schedule_word, start_message
//  out     | out_valid/out_ready| digest_0 .. digest_7
//  cfg     | cfg_valid/cfg_ready| cfg_index (0..7 used), cfg_data
//
// One schedule word is accepted per cycle while in_ready is high; each word is held in the input register,
// and its round runs through the round logic into the working registers when it leaves.
// A digest is loaded into the digest register as the round 63 word leaves, unless that word has to wait.
// If a digest is still waiting when the next round 63 word is ready, that word waits,
// and in_ready falls once the input register is occupied. cfg_ready is always high.
// After reset the chaining value and initial-hash registers hold the standard initial hash.
module sha256_compression_rounds_unit (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  sha256cr_pkg::word_t    schedule_word,
  input  logic                   start_message,
  output logic                   out_valid,
  input  logic                   out_ready,
  output sha256cr_pkg::word_t    digest_0,
  output sha256cr_pkg::word_t    digest_1,
  output sha256cr_pkg::word_t    digest_2,
  output sha256cr_pkg::word_t    digest_3,
  output sha256cr_pkg::word_t    digest_4,
  output sha256cr_pkg::word_t    digest_5,
  output sha256cr_pkg::word_t    digest_6,
  output sha256cr_pkg::word_t    digest_7,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  sha256cr_pkg::cfg_idx_t cfg_index,
  input  sha256cr_pkg::word_t    cfg_data
);
  import sha256cr_pkg::*;

  // Input register.
  logic   in_held;
  word_t  held_word;
  logic   held_start;

  // Round state.
  round_t round;
  hash_t  chain;
  hash_t  work;
  hash_t  digest;

  hash_t  init_hash;
  hash_t  chain_base;
  hash_t  vars_cur;
  hash_t  vars_next;
  logic   fire;
  logic   last_round;

  // Configuration writes never stall.
  assign cfg_ready = 1'b1;

  sha256cr_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (cfg_valid),
    .wr_index  (cfg_index),
    .wr_data   (cfg_data),
    .init_hash (init_hash)
  );

  // A held round runs unless it is the last round and the digest register is still full.
  assign last_round = (round == ROUND_LAST);
  assign fire       = in_held && (!last_round || !out_valid || out_ready);
  assign in_ready   = !in_held || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_held <= 1'b0;
    end else if (in_ready) begin
      in_held <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      held_word  <= schedule_word;
      held_start <= start_message;
    end
  end

  // At round 0 the working words come from the chaining value, restarted if asked.
  always_comb begin
    chain_base = held_start ? init_hash : chain;
    if (round == ROUND_FIRST) begin
      vars_cur = chain_base;
    end else begin
      vars_cur = work;
    end
  end

  sha256cr_round u_round (
    .vars       (vars_cur),
    .sched_word (held_word),
    .round_k    (ROUND_K[round]),
    .vars_next  (vars_next)
  );

  // Round counter and working words.
  always_ff @(posedge clk) begin
    if (rst) begin
      round <= ROUND_FIRST;
    end else if (fire) begin
      round <= round + 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      work <= vars_next;
    end
  end

  // Chaining value: reloaded at a started round 0, updated after round 63.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_WORDS; i++) begin
        chain[i] <= HASH_RESET[i];
      end
    end else if (fire) begin
      if (round == ROUND_FIRST) begin
        chain <= chain_base;
      end else if (last_round) begin
        for (int i = 0; i < NUM_WORDS; i++) begin
          chain[i] <= chain[i] + vars_next[i];
        end
      end
    end
  end

  // Digest register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire && last_round) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && last_round) begin
      for (int i = 0; i < NUM_WORDS; i++) begin
        digest[i] <= chain[i] + vars_next[i];
      end
    end
  end

  assign digest_0 = digest[0];
  assign digest_1 = digest[1];
  assign digest_2 = digest[2];
  assign digest_3 = digest[3];
  assign digest_4 = digest[4];
  assign digest_5 = digest[5];
  assign digest_6 = digest[6];
  assign digest_7 = digest[7];

`ifndef SYNTHESIS
  // The last round always leaves a digest waiting.
  a_last_round_digest: assert property (@(posedge clk) disable iff (rst)
    (fire && last_round) |=> out_valid)
    else $error("round 63 did not produce a digest");

  // The round counter steps by one for each round done.
  a_round_step: assert property (@(posedge clk) disable iff (rst)
    fire |=> (round == $past(round) + 6'd1))
    else $error("round counter did not advance");

  // The round counter holds while no round is done.
  a_round_hold: assert property (@(posedge clk) disable iff (rst)
    !fire |=> $stable(round))
    else $error("round counter moved without a round");

  // Input back-pressure comes only from a waiting digest blocking round 63.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (in_held && last_round && out_valid && !out_ready))
    else $error("input stalled without cause");
`endif

endmodule

[tb/sv/testbench.sv]
// Self-checking testbench for the SHA-256 compression rounds unit.
// Holds a round-by-round predictor, directed and random tests and a digest checker.
// Depends on sha256cr_pkg and sha256_compression_rounds_unit.
module testbench;
  import sha256cr_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int RANDOM_WORDS = 1050;
  localparam int SETTLE_CYCLES = 4;

  // Register indexes of the configuration channel.
  localparam cfg_idx_t INIT_HASH_BASE = cfg_idx_t'(0);
  localparam cfg_idx_t INIT_HASH_END  = cfg_idx_t'(NUM_WORDS);
  localparam cfg_idx_t CFG_IDX_MAX    = '1;

  typedef enum int {PAT_ZERO, PAT_ONES, PAT_ALTERNATE, PAT_RANDOM, PAT_MIXED} word_pattern_e;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     in_valid = 1'b0;
  logic     in_ready;
  word_t    schedule_word = '0;
  logic     start_message = 1'b0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  word_t    digest_0, digest_1, digest_2, digest_3;
  word_t    digest_4, digest_5, digest_6, digest_7;
  logic     cfg_valid = 1'b0;
  logic     cfg_ready;
  cfg_idx_t cfg_index = '0;
  word_t    cfg_data = '0;

  // Predictor state: its own copy of the registers, chaining value and round counter.
  word_t  model_init_hash [NUM_WORDS];
  word_t  model_chain [NUM_WORDS];
  word_t  model_work [NUM_WORDS];
  round_t model_round;

  hash_t expected_digests [$];
  int    mismatch_count = 0;
  int    cycle_count = 0;
  int    words_sent = 0;
  int    sink_stall = 0;
  bit    source_burst = 1'b0;
  bit    sink_burst = 1'b0;

  sha256_compression_rounds_unit i_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .schedule_word (schedule_word),
    .start_message (start_message),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .digest_0      (digest_0),
    .digest_1      (digest_1),
    .digest_2      (digest_2),
    .digest_3      (digest_3),
    .digest_4      (digest_4),
    .digest_5      (digest_5),
    .digest_6      (digest_6),
    .digest_7      (digest_7),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog: a run that stalls past the limit is a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("** sha256_compression_rounds_unit: FAILED **");
      $finish;
    end
  end

  function automatic word_t rotr(input word_t x, input int n);
    return (x >> n) | (x << (WORD_W - n));
  endfunction

  // One SHA-256 round on the predictor state; returns 1 with the new digest after round 63.
  function automatic bit run_round(input word_t w, input logic restart, output hash_t digest);
    word_t s1, ch, s0, mj, t1, t2;
    digest = '0;
    if (model_round == ROUND_FIRST) begin
      if (restart) model_chain = model_init_hash;
      model_work = model_chain;
    end
    s1 = rotr(model_work[4], 6) ^ rotr(model_work[4], 11) ^ rotr(model_work[4], 25);
    ch = (model_work[4] & model_work[5]) ^ (~model_work[4] & model_work[6]);
    t1 = model_work[7] + s1 + ch + ROUND_K[model_round] + w;
    s0 = rotr(model_work[0], 2) ^ rotr(model_work[0], 13) ^ rotr(model_work[0], 22);
    mj = (model_work[0] & model_work[1]) ^ (model_work[0] & model_work[2])
       ^ (model_work[1] & model_work[2]);
    t2 = s0 + mj;
    for (int j = NUM_WORDS - 1; j > 0; j--) model_work[j] = model_work[j-1];
    model_work[4] = model_work[4] + t1;
    model_work[0] = t1 + t2;
    if (model_round == ROUND_LAST) begin
      for (int j = 0; j < NUM_WORDS; j++) begin
        model_chain[j] = model_chain[j] + model_work[j];
        digest[j] = model_chain[j];
      end
      model_round = ROUND_FIRST;
      return 1'b1;
    end
    model_round = model_round + 1'b1;
    return 1'b0;
  endfunction

  // Gaps are mostly short with the odd long one; burst phases have none.
  function automatic int pick_gap(input bit burst, input int long_max);
    int r;
    r = $urandom_range(0, 99);
    if (burst || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, long_max);
  endfunction

  function automatic word_t pattern_word(input word_pattern_e pat, input int idx);
    int r;
    case (pat)
      PAT_ZERO:      return '0;
      PAT_ONES:      return '1;
      PAT_ALTERNATE: return idx[0] ? 32'haaaaaaaa : 32'h55555555;
      PAT_RANDOM:    return $urandom;
      default: begin
        r = $urandom_range(0, 9);
        if (r == 0) return '0;
        if (r == 1) return '1;
        return $urandom;
      end
    endcase
  endfunction

  // The result side stalls at random, driven on the falling edge.
  always @(negedge clk) begin
    if (sink_stall > 0) begin
      out_ready <= 1'b0;
      sink_stall <= sink_stall - 1;
    end else begin
      out_ready <= 1'b1;
      sink_stall <= pick_gap(sink_burst, 100);
    end
  end

  // Each digest transaction is checked against the oldest prediction.
  always @(posedge clk) begin : check_digest
    hash_t seen, want;
    if (!rst && out_valid && out_ready) begin
      seen = {digest_7, digest_6, digest_5, digest_4, digest_3, digest_2, digest_1, digest_0};
      if (expected_digests.size() == 0) begin
        $display("%0t unexpected digest: expected none, actual %h", $time, seen);
        mismatch_count++;
      end else begin
        want = expected_digests.pop_front();
        for (int j = 0; j < NUM_WORDS; j++) begin
          if (seen[j] !== want[j]) begin
            $display("%0t digest_%0d mismatch: expected %h, actual %h",
                     $time, j, want[j], seen[j]);
            mismatch_count++;
          end
        end
      end
    end
  end

  // Sends one schedule word, predicts its effect, then idles the input for a random gap.
  task automatic send_round_word(input word_t w, input logic restart);
    hash_t digest;
    int gap;
    @(negedge clk);
    in_valid <= 1'b1;
    schedule_word <= w;
    start_message <= restart;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (run_round(w, restart, digest)) expected_digests.push_back(digest);
    words_sent++;
    gap = pick_gap(source_burst, 40);
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
  endtask

  // Sends a run of words; the start flag is set by chance, separately for round 0 and the rest.
  task automatic send_words(input int count, input word_pattern_e pat,
                            input int restart_pct, input int stray_pct);
    logic restart;
    for (int i = 0; i < count; i++) begin
      if (model_round == ROUND_FIRST) restart = ($urandom_range(0, 99) < restart_pct);
      else restart = ($urandom_range(0, 99) < stray_pct);
      send_round_word(pattern_word(pat, i), restart);
    end
  endtask

  // Waits until every digest has arrived and the last round has left the pipeline.
  task automatic settle_block();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_digests.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_init_hash(input cfg_idx_t idx, input word_t value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx < INIT_HASH_END) model_init_hash[3'(idx - INIT_HASH_BASE)] = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic write_all_init_hash(input word_pattern_e pat);
    for (int j = 0; j < NUM_WORDS; j++)
      write_init_hash(cfg_idx_t'(INIT_HASH_BASE + j), pattern_word(pat, j));
  endtask

  // Blocks from the reset initial hash with all-zero and all-one schedule words.
  task automatic test_reset_hash();
    send_words(64, PAT_ZERO, 100, 0);
    send_words(64, PAT_ONES, 100, 0);
  endtask

  // No restart at round 0, and a start flag on every later round that must be ignored.
  task automatic test_stray_start();
    send_words(64, PAT_ALTERNATE, 0, 100);
  endtask

  // Register writes take effect only at the next restarted block; unused indexes are ignored.
  task automatic test_init_hash_regs();
    settle_block();
    write_all_init_hash(PAT_ZERO);
    write_init_hash(INIT_HASH_END, $urandom);
    write_init_hash(CFG_IDX_MAX, $urandom);
    send_words(64, PAT_RANDOM, 100, 0);
    settle_block();
    write_all_init_hash(PAT_ONES);
    send_words(64, PAT_RANDOM, 0, 0);
    send_words(64, PAT_RANDOM, 100, 0);
    // A write in the middle of a block leaves that block undisturbed.
    send_words(20, PAT_RANDOM, 100, 0);
    settle_block();
    write_all_init_hash(PAT_RANDOM);
    send_words(44, PAT_RANDOM, 100, 100);
    send_words(64, PAT_RANDOM, 100, 0);
  endtask

  // Random phases: mostly whole blocks, some partial runs, with register writes between.
  task automatic test_random_traffic();
    int last_word, writes, count;
    word_t value;
    cfg_idx_t idx;
    last_word = words_sent + RANDOM_WORDS;
    while (words_sent < last_word) begin
      source_burst = ($urandom_range(0, 4) == 0);
      sink_burst = ($urandom_range(0, 4) == 0);
      writes = $urandom_range(0, 4);
      if (writes > 0) settle_block();
      repeat (writes) begin
        if ($urandom_range(0, 4) == 0) idx = cfg_idx_t'($urandom_range(NUM_WORDS, CFG_IDX_MAX));
        else idx = cfg_idx_t'(INIT_HASH_BASE + $urandom_range(0, NUM_WORDS - 1));
        value = pattern_word(PAT_MIXED, 0);
        write_init_hash(idx, value);
      end
      if ($urandom_range(0, 3) != 0)
        count = (64 - int'(model_round)) + 64 * $urandom_range(0, 2);
      else
        count = $urandom_range(1, 150);
      send_words(count, PAT_MIXED, 75, 25);
    end
  endtask

  initial begin
    model_init_hash = HASH_RESET;
    model_chain = HASH_RESET;
    for (int j = 0; j < NUM_WORDS; j++) model_work[j] = '0;
    model_round = ROUND_FIRST;
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    test_reset_hash();
    test_stray_start();
    test_init_hash_regs();
    test_random_traffic();

    settle_block();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && expected_digests.size() == 0) begin
      $display("** sha256_compression_rounds_unit: PASSED **");
    end else begin
      $display("** sha256_compression_rounds_unit: FAILED **");
    end
    $finish;
  end

endmodule

[sim.f]
hdl/sha256cr_pkg.sv
hdl/sha256cr_cfg_regs.sv
hdl/sha256cr_round.sv
hdl/sha256_compression_rounds_unit.sv
tb/sv/testbench.sv
